// ===== rtl/segi_pkg.sv =====
// Shared types, outcome codes and default sizes for the segment intersection core.
`default_nettype none

package segi_pkg;

  // Default sizes of the arithmetic.
  localparam int CoordBitsDef     = 16;
  localparam int ParamFracBitsDef = 16;
  localparam int PointFracBitsDef = 8;

  // Fixed widths of the transfer fields.
  localparam int InW       = 16;
  localparam int CoordMaxW = 24;
  localparam int RemW      = 32;
  localparam int PointW    = 24;

  typedef enum logic [1:0] {
    OutHit       = 2'd0,
    OutOutside   = 2'd1,
    OutParallel  = 2'd2,
    OutCollinear = 2'd3
  } outcome_e;

  typedef struct packed {
    logic signed [InW-1:0] first_start_x;
    logic signed [InW-1:0] first_start_y;
    logic signed [InW-1:0] first_end_x;
    logic signed [InW-1:0] first_end_y;
    logic signed [InW-1:0] second_start_x;
    logic signed [InW-1:0] second_start_y;
    logic signed [InW-1:0] second_end_x;
    logic signed [InW-1:0] second_end_y;
  } seg_in_t;

  typedef struct packed {
    outcome_e                 outcome;
    logic signed [RemW-1:0]   first_remaining;
    logic signed [RemW-1:0]   second_remaining;
    logic signed [PointW-1:0] cross_x;
    logic signed [PointW-1:0] cross_y;
  } seg_out_t;

endpackage

`default_nettype wire

// ===== rtl/segment_intersection_core.sv =====
// Top level of the segment intersection core: cross products, classification and division.
// The pipeline depth from start to done_o is set by the bit-per-stage dividers.
// Throughput: one segment pair per cycle, every cycle; busy is never raised.
// Reset clears only the valid bits of the pipeline, so done_o is low after reset.
// The receiver cannot stall: each result is shown for exactly one cycle with done_o high.
`default_nettype none

module segment_intersection_core #(
  parameter int COORD_BITS      = segi_pkg::CoordBitsDef,
  parameter int PARAM_FRAC_BITS = segi_pkg::ParamFracBitsDef,
  parameter int POINT_FRAC_BITS = segi_pkg::PointFracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  segi_pkg::seg_in_t  seg_i,
  output logic               done_o,
  output segi_pkg::seg_out_t result_o
);

  // Difference, product, numerator and magnitude widths.
  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int NW  = PW + 1;
  localparam int RW  = PW + 2;
  localparam int MW  = PW + 1;
  localparam int KR  = segi_pkg::RemW;
  localparam int KP  = DW + POINT_FRAC_BITS;
  localparam int DIV_LAT = (KR > KP) ? KR : KP;
  localparam int NBW = MW + PARAM_FRAC_BITS + KR;
  localparam int PPW = KP + PW;
  localparam int VW  = COORD_BITS + POINT_FRAC_BITS + segi_pkg::PointW + 2;

  localparam logic signed [VW-1:0] PMax = VW'(2 ** (segi_pkg::PointW - 1) - 1);
  localparam logic signed [VW-1:0] PMin = -PMax - VW'(1);

  localparam logic [KR-1:0] RemPosMax = {1'b0, {(KR-1){1'b1}}};
  localparam logic [KR-1:0] RemNegMax = {1'b1, {(KR-1){1'b0}}};

  // The pipeline never holds an item back.
  assign busy = 1'b0;

  // Only the low COORD_BITS of each field take part, sign-extended.
  function automatic logic signed [COORD_BITS-1:0] crd(input logic [segi_pkg::InW-1:0] f);
    logic [segi_pkg::CoordMaxW-1:0] e;
    e = {{(segi_pkg::CoordMaxW - segi_pkg::InW){f[segi_pkg::InW-1]}}, f};
    return e[COORD_BITS-1:0];
  endfunction

  // One minus a segment parameter: clamp the magnitude and apply the sign.
  function automatic logic [KR-1:0] fin_rem(input logic neg, input logic sat,
                                            input logic [KR-1:0] q);
    logic [KR-1:0] r;
    if (neg) begin
      r = (sat || (q > RemNegMax)) ? RemNegMax : KR'(-q);
    end else begin
      r = (sat || q[KR-1]) ? RemPosMax : q;
    end
    return r;
  endfunction

  // Crossing coordinate: start point plus signed offset, clamped to the output range.
  function automatic logic [segi_pkg::PointW-1:0] fin_pt(input logic signed [COORD_BITS-1:0] a,
                                                         input logic neg,
                                                         input logic [KP-1:0] q);
    logic signed [VW-1:0] base;
    logic signed [VW-1:0] off;
    logic signed [VW-1:0] v;
    base = VW'(a);
    base = base <<< POINT_FRAC_BITS;
    off  = VW'(q);
    if (neg) begin
      off = -off;
    end
    v = base + off;
    if (v > PMax) begin
      v = PMax;
    end else if (v < PMin) begin
      v = PMin;
    end
    return v[segi_pkg::PointW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Stage 1: coordinate differences.
  // ---------------------------------------------------------------------------
  logic                         v1_q;
  logic signed [COORD_BITS-1:0] ax1_q, ay1_q;
  logic signed [DW-1:0]         e1x1_q, e1y1_q, e2x1_q, e2y1_q, acx1_q, acy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    ax1_q  <= crd(seg_i.first_start_x);
    ay1_q  <= crd(seg_i.first_start_y);
    e1x1_q <= DW'(crd(seg_i.first_end_x)) - DW'(crd(seg_i.first_start_x));
    e1y1_q <= DW'(crd(seg_i.first_end_y)) - DW'(crd(seg_i.first_start_y));
    e2x1_q <= DW'(crd(seg_i.second_end_x)) - DW'(crd(seg_i.second_start_x));
    e2y1_q <= DW'(crd(seg_i.second_end_y)) - DW'(crd(seg_i.second_start_y));
    acx1_q <= DW'(crd(seg_i.first_start_x)) - DW'(crd(seg_i.second_start_x));
    acy1_q <= DW'(crd(seg_i.first_start_y)) - DW'(crd(seg_i.second_start_y));
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the six cross-product terms.
  // ---------------------------------------------------------------------------
  logic                         v2_q;
  logic signed [COORD_BITS-1:0] ax2_q, ay2_q;
  logic signed [DW-1:0]         e1x2_q, e1y2_q;
  logic signed [PW-1:0]         p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax2_q  <= ax1_q;
    ay2_q  <= ay1_q;
    e1x2_q <= e1x1_q;
    e1y2_q <= e1y1_q;
    p1_q   <= PW'(acy1_q) * PW'(e2x1_q);
    p2_q   <= PW'(acx1_q) * PW'(e2y1_q);
    p3_q   <= PW'(e1x1_q) * PW'(e2y1_q);
    p4_q   <= PW'(e1y1_q) * PW'(e2x1_q);
    p5_q   <= PW'(acy1_q) * PW'(e1x1_q);
    p6_q   <= PW'(acx1_q) * PW'(e1y1_q);
  end

  // ---------------------------------------------------------------------------
  // Stage 3: numerators and the common denominator.
  // ---------------------------------------------------------------------------
  logic                         v3_q;
  logic signed [COORD_BITS-1:0] ax3_q, ay3_q;
  logic signed [DW-1:0]         e1x3_q, e1y3_q;
  logic signed [NW-1:0]         nr3_q, den3_q, ns3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax3_q  <= ax2_q;
    ay3_q  <= ay2_q;
    e1x3_q <= e1x2_q;
    e1y3_q <= e1y2_q;
    nr3_q  <= NW'(p1_q) - NW'(p2_q);
    den3_q <= NW'(p3_q) - NW'(p4_q);
    ns3_q  <= NW'(p5_q) - NW'(p6_q);
  end

  // ---------------------------------------------------------------------------
  // Stage 4: make the denominator positive, note the degenerate cases and take
  // the magnitudes of the first segment's direction.
  // ---------------------------------------------------------------------------
  logic                         v4_q;
  logic signed [COORD_BITS-1:0] ax4_q, ay4_q;
  logic [DW-1:0]                dax4_q, day4_q;
  logic                         dnx4_q, dny4_q;
  logic signed [NW-1:0]         nr4_q, den4_q, ns4_q;
  logic                         zero4_q, colin4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax4_q    <= ax3_q;
    ay4_q    <= ay3_q;
    dnx4_q   <= e1x3_q[DW-1];
    dny4_q   <= e1y3_q[DW-1];
    dax4_q   <= e1x3_q[DW-1] ? DW'(-e1x3_q) : DW'(e1x3_q);
    day4_q   <= e1y3_q[DW-1] ? DW'(-e1y3_q) : DW'(e1y3_q);
    den4_q   <= den3_q[NW-1] ? -den3_q : den3_q;
    nr4_q    <= den3_q[NW-1] ? -nr3_q  : nr3_q;
    ns4_q    <= den3_q[NW-1] ? -ns3_q  : ns3_q;
    zero4_q  <= (den3_q == '0);
    colin4_q <= (nr3_q == '0);
  end

  // ---------------------------------------------------------------------------
  // Stage 5: classify, form den - num for both segments and the products that
  // scale the direction by the first parameter's numerator.
  // ---------------------------------------------------------------------------
  logic                         v5_q;
  logic signed [COORD_BITS-1:0] ax5_q, ay5_q;
  logic                         dnx5_q, dny5_q;
  logic signed [RW-1:0]         rr5_q, rs5_q;
  logic [PW-1:0]                den5_q;
  logic [DW+PW-1:0]             prx5_q, pry5_q;
  segi_pkg::outcome_e           cls5_q;
  segi_pkg::outcome_e           cls5_d;
  logic                         hit5;

  assign hit5 = !nr4_q[NW-1] && (nr4_q <= den4_q) && !ns4_q[NW-1] && (ns4_q <= den4_q);

  always_comb begin
    if (zero4_q) begin
      cls5_d = colin4_q ? segi_pkg::OutCollinear : segi_pkg::OutParallel;
    end else begin
      cls5_d = hit5 ? segi_pkg::OutHit : segi_pkg::OutOutside;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax5_q  <= ax4_q;
    ay5_q  <= ay4_q;
    dnx5_q <= dnx4_q;
    dny5_q <= dny4_q;
    cls5_q <= cls5_d;
    den5_q <= den4_q[PW-1:0];
    rr5_q  <= RW'(den4_q) - RW'(nr4_q);
    rs5_q  <= RW'(den4_q) - RW'(ns4_q);
    prx5_q <= (DW+PW)'(dax4_q) * (DW+PW)'(nr4_q[PW-1:0]);
    pry5_q <= (DW+PW)'(day4_q) * (DW+PW)'(nr4_q[PW-1:0]);
  end

  // ---------------------------------------------------------------------------
  // Stage 6: magnitudes, overflow checks and the divider start values. The
  // overflow check compares the integer part of the quotient with its limit.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    segi_pkg::outcome_e           cls;
    logic                         negr;
    logic                         negs;
    logic                         satr;
    logic                         sats;
    logic                         dnx;
    logic                         dny;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
  } side_t;

  logic          v6_q;
  side_t         side6_q;
  side_t         side6_d;
  logic [PW-1:0] den6_q;
  logic [PW-1:0] remr6_q, rems6_q, remx6_q, remy6_q;
  logic [KR-1:0] lowr6_q, lows6_q;
  logic [KP-1:0] lowx6_q, lowy6_q;

  logic [MW-1:0]  magr, mags;
  logic [NBW-1:0] nbr, nbs;
  logic [PPW-1:0] npx, npy;

  always_comb begin
    magr = rr5_q[RW-1] ? MW'(-rr5_q) : MW'(rr5_q);
    mags = rs5_q[RW-1] ? MW'(-rs5_q) : MW'(rs5_q);
    nbr  = NBW'(magr) << PARAM_FRAC_BITS;
    nbs  = NBW'(mags) << PARAM_FRAC_BITS;
    npx  = PPW'(prx5_q) << POINT_FRAC_BITS;
    npy  = PPW'(pry5_q) << POINT_FRAC_BITS;
    side6_d.cls  = cls5_q;
    side6_d.negr = rr5_q[RW-1];
    side6_d.negs = rs5_q[RW-1];
    side6_d.satr = ((nbr >> KR) >= NBW'(den5_q));
    side6_d.sats = ((nbs >> KR) >= NBW'(den5_q));
    side6_d.dnx  = dnx5_q;
    side6_d.dny  = dny5_q;
    side6_d.ax   = ax5_q;
    side6_d.ay   = ay5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side6_q <= side6_d;
    den6_q  <= den5_q;
    remr6_q <= nbr[KR+PW-1:KR];
    lowr6_q <= nbr[KR-1:0];
    rems6_q <= nbs[KR+PW-1:KR];
    lows6_q <= nbs[KR-1:0];
    remx6_q <= npx[KP+PW-1:KP];
    lowx6_q <= npx[KP-1:0];
    remy6_q <= npy[KP+PW-1:KP];
    lowy6_q <= npy[KP-1:0];
  end

  // ---------------------------------------------------------------------------
  // Dividers: all four run in lock step with the same latency.
  // ---------------------------------------------------------------------------
  logic [KR-1:0] qr, qs;
  logic [KP-1:0] qx, qy;

  segi_div #(.DEN_W(PW), .QBITS(KR), .LAT(DIV_LAT)) u_div_r (
    .clk_i (clk_i),
    .rem_i (remr6_q),
    .den_i (den6_q),
    .low_i (lowr6_q),
    .quot_o(qr)
  );

  segi_div #(.DEN_W(PW), .QBITS(KR), .LAT(DIV_LAT)) u_div_s (
    .clk_i (clk_i),
    .rem_i (rems6_q),
    .den_i (den6_q),
    .low_i (lows6_q),
    .quot_o(qs)
  );

  segi_div #(.DEN_W(PW), .QBITS(KP), .LAT(DIV_LAT)) u_div_x (
    .clk_i (clk_i),
    .rem_i (remx6_q),
    .den_i (den6_q),
    .low_i (lowx6_q),
    .quot_o(qx)
  );

  segi_div #(.DEN_W(PW), .QBITS(KP), .LAT(DIV_LAT)) u_div_y (
    .clk_i (clk_i),
    .rem_i (remy6_q),
    .den_i (den6_q),
    .low_i (lowy6_q),
    .quot_o(qy)
  );

  // Side information travels alongside the dividers.
  side_t side_q [DIV_LAT];
  logic  vd_q   [DIV_LAT];

  always_ff @(posedge clk_i) begin
    side_q[0] <= side6_q;
    for (int i = 1; i < DIV_LAT; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        vd_q[i] <= 1'b0;
      end
    end else begin
      vd_q[0] <= v6_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        vd_q[i] <= vd_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: saturation, sign and masking by outcome.
  // ---------------------------------------------------------------------------
  side_t              sd;
  segi_pkg::seg_out_t res_d;
  segi_pkg::seg_out_t res_q;
  logic               done_q;

  assign sd = side_q[DIV_LAT-1];

  always_comb begin
    res_d = '0;
    res_d.outcome = sd.cls;
    case (sd.cls)
      segi_pkg::OutHit: begin
        res_d.first_remaining  = fin_rem(sd.negr, sd.satr, qr);
        res_d.second_remaining = fin_rem(sd.negs, sd.sats, qs);
        res_d.cross_x          = fin_pt(sd.ax, sd.dnx, qx);
        res_d.cross_y          = fin_pt(sd.ay, sd.dny, qy);
      end
      segi_pkg::OutOutside: begin
        res_d.first_remaining  = fin_rem(sd.negr, sd.satr, qr);
        res_d.second_remaining = fin_rem(sd.negs, sd.sats, qs);
      end
      default: begin
        // Parallel and collinear pairs carry only the outcome.
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vd_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// ===== rtl/segi_div.sv =====
// Pipelined restoring divider that produces one quotient bit per register stage.
`default_nettype none

module segi_div #(
  parameter int DEN_W = 34,
  parameter int QBITS = 32,
  parameter int LAT   = 32
) (
  input  logic             clk_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [QBITS-1:0] low_i,
  output logic [QBITS-1:0] quot_o
);

  // Partial remainder and divisor are only needed up to the last stage.
  logic [DEN_W-1:0] rem_q [QBITS-1];
  logic [DEN_W-1:0] den_q [QBITS-1];
  logic [QBITS-1:0] low_q [QBITS];

  for (genvar s = 0; s < QBITS; s++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QBITS-1:0] low_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in = rem_i;
      assign den_in = den_i;
      assign low_in = low_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign low_in = low_q[s-1];
    end

    // Bring down the next dividend bit and try the subtraction.
    assign trial = {rem_in, low_in[QBITS-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      low_q[s] <= {low_in[QBITS-2:0], ge};
    end

    if (s < QBITS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[s] <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        den_q[s] <= den_in;
      end
    end
  end

  if (LAT > QBITS) begin : g_pad
    logic [QBITS-1:0] pad_q [LAT-QBITS];
    always_ff @(posedge clk_i) begin
      pad_q[0] <= low_q[QBITS-1];
      for (int i = 1; i < LAT - QBITS; i++) begin
        pad_q[i] <= pad_q[i-1];
      end
    end
    assign quot_o = pad_q[LAT-QBITS-1];
  end else begin : g_nopad
    assign quot_o = low_q[QBITS-1];
  end

endmodule

`default_nettype wire

// ===== rtl/segi_chk.sv =====
// Port-level checker for the segment intersection core, with its bind statement.
`default_nettype none

module segi_chk #(
  parameter int COORD_BITS      = segi_pkg::CoordBitsDef,
  parameter int PARAM_FRAC_BITS = segi_pkg::ParamFracBitsDef,
  parameter int POINT_FRAC_BITS = segi_pkg::PointFracBitsDef
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input segi_pkg::seg_in_t  seg_i,
  input logic               done_o,
  input segi_pkg::seg_out_t result_o
);

  localparam int KP  = COORD_BITS + 1 + POINT_FRAC_BITS;
  localparam int LAT = 7 + ((segi_pkg::RemW > KP) ? segi_pkg::RemW : KP);
  localparam logic signed [segi_pkg::RemW-1:0] One = segi_pkg::RemW'(1) << PARAM_FRAC_BITS;

  logic acc;
  assign acc = start && !busy && (seg_i == seg_i);

  // Every transfer in gives exactly one result.
  a_lat_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##LAT done_o) else $error("missing result");

  a_lat_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc, LAT)) else $error("result without transfer");

  // Degenerate pairs carry nothing but the outcome.
  a_degenerate : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.outcome == segi_pkg::OutParallel ||
               result_o.outcome == segi_pkg::OutCollinear)
    |-> result_o.first_remaining == '0 && result_o.second_remaining == '0 &&
        result_o.cross_x == '0 && result_o.cross_y == '0)
    else $error("degenerate result has payload");

  // A hit lies on both segments, so one minus each parameter is within [0, 1].
  a_hit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.outcome == segi_pkg::OutHit
    |-> result_o.first_remaining >= 0 && result_o.first_remaining <= One &&
        result_o.second_remaining >= 0 && result_o.second_remaining <= One)
    else $error("hit parameter out of range");

  a_outside : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.outcome == segi_pkg::OutOutside
    |-> result_o.cross_x == '0 && result_o.cross_y == '0)
    else $error("outside crossing has a point");

endmodule

bind segment_intersection_core segi_chk #(
  .COORD_BITS     (COORD_BITS),
  .PARAM_FRAC_BITS(PARAM_FRAC_BITS),
  .POINT_FRAC_BITS(POINT_FRAC_BITS)
) u_segi_chk (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .seg_i   (seg_i),
  .done_o  (done_o),
  .result_o(result_o)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the segment intersection core: directed table then random pairs.
`default_nettype none

module tb_top;

  localparam int Latency   = 39;
  localparam int NumRandom = 1100;
  localparam int CycleCap  = 200000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  segi_pkg::seg_in_t  seg_i = '0;
  logic               done_o;
  segi_pkg::seg_out_t result_o;

  segment_intersection_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .seg_i   (seg_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always #1 clk_i = ~clk_i;

  // Results still owed by the core, oldest first.
  segi_pkg::seg_out_t pending_results[$];
  int                 fail_count = 0;
  int                 cycle_count = 0;

  // Magnitude of num over den in Q16.16, truncated and saturated, with the sign of num.
  function automatic logic signed [31:0] fixed_ratio(longint num, longint den);
    longint unsigned n, d, q, rem;
    n = (num < 0) ? -num : num;
    d = den;
    q = n / d;
    rem = n % d;
    if (q >= (64'd1 << (32 - segi_pkg::ParamFracBitsDef))) begin
      q = 64'd1 << 32;
    end else begin
      for (int i = 0; i < segi_pkg::ParamFracBitsDef; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= d) begin
          rem = rem - d;
          q = q | 64'd1;
        end
      end
    end
    if (num < 0) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return 32'(q);
  endfunction

  // Point a + (b - a) * num / den in Q.8, the offset truncated toward zero, then saturated.
  function automatic logic signed [23:0] crossing_coord(longint a, longint b,
                                                         longint num, longint den);
    longint delta, off, v;
    longint unsigned mag_delta;
    delta = b - a;
    mag_delta = (delta < 0) ? -delta : delta;
    off = ((mag_delta << segi_pkg::PointFracBitsDef) * num) / den;
    if (delta < 0) off = -off;
    v = a * (64'sd1 <<< segi_pkg::PointFracBitsDef) + off;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic segi_pkg::seg_out_t intersect_segments(segi_pkg::seg_in_t p);
    longint ax, ay, bx, by, cx, cy, dx, dy, num_r, den, num_s;
    segi_pkg::seg_out_t r;
    ax = p.first_start_x;  ay = p.first_start_y;
    bx = p.first_end_x;    by = p.first_end_y;
    cx = p.second_start_x; cy = p.second_start_y;
    dx = p.second_end_x;   dy = p.second_end_y;
    num_r = (ay - cy) * (dx - cx) - (ax - cx) * (dy - cy);
    den   = (bx - ax) * (dy - cy) - (by - ay) * (dx - cx);
    num_s = (ay - cy) * (bx - ax) - (ax - cx) * (by - ay);
    r = '0;
    if (den == 0) begin
      r.outcome = (num_r == 0) ? segi_pkg::OutCollinear : segi_pkg::OutParallel;
      return r;
    end
    if (den < 0) begin
      den = -den; num_r = -num_r; num_s = -num_s;
    end
    r.first_remaining  = fixed_ratio(den - num_r, den);
    r.second_remaining = fixed_ratio(den - num_s, den);
    if (num_r < 0 || num_r > den || num_s < 0 || num_s > den) begin
      r.outcome = segi_pkg::OutOutside;
      return r;
    end
    r.outcome = segi_pkg::OutHit;
    r.cross_x = crossing_coord(ax, bx, num_r, den);
    r.cross_y = crossing_coord(ay, by, num_r, den);
    return r;
  endfunction

  // Directed rows. Where has_fixed is set, fixed_result is typed in by hand.
  typedef struct {
    segi_pkg::seg_in_t  pair;
    logic               has_fixed;
    segi_pkg::seg_out_t fixed_result;
  } directed_row_t;

  function automatic segi_pkg::seg_in_t make_pair(int ax, int ay, int bx, int by,
                                                  int cx, int cy, int dx, int dy);
    segi_pkg::seg_in_t p;
    p.first_start_x = 16'(ax);  p.first_start_y = 16'(ay);
    p.first_end_x = 16'(bx);    p.first_end_y = 16'(by);
    p.second_start_x = 16'(cx); p.second_start_y = 16'(cy);
    p.second_end_x = 16'(dx);   p.second_end_y = 16'(dy);
    return p;
  endfunction

  function automatic segi_pkg::seg_out_t make_result(segi_pkg::outcome_e o, int r1, int r2,
                                                     int px, int py);
    segi_pkg::seg_out_t r;
    r.outcome = o;
    r.first_remaining = r1;
    r.second_remaining = r2;
    r.cross_x = 24'(px);
    r.cross_y = 24'(py);
    return r;
  endfunction

  directed_row_t directed_rows[$];

  task automatic add_row(segi_pkg::seg_in_t pair, logic has_fixed,
                         segi_pkg::seg_out_t fixed_result);
    directed_row_t row;
    row.pair = pair;
    row.has_fixed = has_fixed;
    row.fixed_result = fixed_result;
    directed_rows = {directed_rows, row};
  endtask

  initial begin
    // All points equal: every term is zero, so the pair is collinear.
    add_row(make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            make_result(segi_pkg::OutCollinear, 0, 0, 0, 0));
    // Two lines along the x axis overlapping.
    add_row(make_pair(0, 0, 10, 0, 5, 0, 20, 0), 1'b1,
            make_result(segi_pkg::OutCollinear, 0, 0, 0, 0));
    // Parallel horizontal lines one unit apart.
    add_row(make_pair(0, 0, 10, 0, 0, 1, 10, 1), 1'b1,
            make_result(segi_pkg::OutParallel, 0, 0, 0, 0));
    // A plain cross at the centre of both segments: 1 - 0.5 on both, point (5,5).
    add_row(make_pair(0, 0, 10, 10, 0, 10, 10, 0), 1'b1,
            make_result(segi_pkg::OutHit, 32'h8000, 32'h8000, 5 * 256, 5 * 256));
    // Touching at an end point on each segment.
    add_row(make_pair(0, 0, 4, 0, 4, 0, 4, 4), 1'b0, '0);
    add_row(make_pair(0, 0, 4, 0, 0, 0, 0, 4), 1'b0, '0);
    // Lines cross beyond the end of one segment.
    add_row(make_pair(0, 0, 1, 0, 5, -5, 5, 5), 1'b0, '0);
    add_row(make_pair(0, 0, 10, 0, 5, 1, 5, 9), 1'b0, '0);
    // Extremes of the coordinate range.
    add_row(make_pair(-32768, -32768, 32767, 32767,
                      -32768, 32767, 32767, -32768), 1'b0, '0);
    add_row(make_pair(32767, 32767, 32767, 32767,
                      32767, 32767, 32767, 32767), 1'b1,
            make_result(segi_pkg::OutCollinear, 0, 0, 0, 0));
    add_row(make_pair(-32768, -32768, -32768, -32768,
                      32767, 32767, 32767, 32767), 1'b1,
            make_result(segi_pkg::OutCollinear, 0, 0, 0, 0));
    add_row(make_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767), 1'b0, '0);
    // Near-parallel: a hit at the middle, then tiny denominators that saturate remainders.
    add_row(make_pair(-32768, 0, 32767, 1, -32768, 1, 32767, 0), 1'b0, '0);
    add_row(make_pair(0, 0, 1, 0, -32768, -32768, 32767, -32767), 1'b0, '0);
    add_row(make_pair(0, 0, 1, 0, 32767, -32768, -32768, -32767), 1'b0, '0);
    // Negative denominator orientation and a crossing at a fraction.
    add_row(make_pair(10, 10, 0, 0, 10, 0, 0, 10), 1'b0, '0);
    add_row(make_pair(0, 0, 3, 1, 0, 1, 3, 0), 1'b0, '0);
    add_row(make_pair(-7, 3, 5, -9, 2, 8, -4, -6), 1'b0, '0);
    // Degenerate first segment lying off the second: den zero, num_r not.
    add_row(make_pair(1, 1, 1, 1, 0, 0, 5, 0), 1'b1,
            make_result(segi_pkg::OutParallel, 0, 0, 0, 0));
  end

  // Compare each transfer out of the core with the oldest outstanding prediction.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result_o);
        fail_count <= fail_count + 1;
      end else begin
        segi_pkg::seg_out_t want;
        want = pending_results.pop_front();
        if (result_o.outcome !== want.outcome ||
            result_o.first_remaining !== want.first_remaining ||
            result_o.second_remaining !== want.second_remaining ||
            result_o.cross_x !== want.cross_x ||
            result_o.cross_y !== want.cross_y) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, result_o);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  // Timeout guard.
  initial begin
    wait (cycle_count >= CycleCap);
    $display("end of test: mismatches");
    $finish;
  end

  // Drive one pair; it counts as transferred at the edge where start is high and busy low.
  task automatic send_pair(segi_pkg::seg_in_t p, segi_pkg::seg_out_t want);
    seg_i <= p;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    pending_results = {pending_results, want};
  endtask

  // Random gap before the next transfer; none during the quiet stretch.
  task automatic maybe_idle(bit quiet);
    if (!quiet) begin
      while ($urandom_range(99) < 14) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  function automatic logic [15:0] rand_coord(int span);
    if (span == 0) return 16'($urandom());
    return 16'($urandom_range(2 * span) - span);
  endfunction

  // Mostly small coordinates so that hits and crossings are common; some full range.
  function automatic segi_pkg::seg_in_t random_pair();
    segi_pkg::seg_in_t p;
    int span;
    int kind;
    kind = $urandom_range(9);
    span = (kind < 5) ? 20 : (kind < 8) ? 2000 : 0;
    p = {rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
         rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span)};
    if (kind == 9 && $urandom_range(1)) begin
      // Parallel or collinear: second segment is a shifted copy of the first.
      p.second_start_x = 16'(p.first_start_x + $urandom_range(3));
      p.second_start_y = 16'(p.first_start_y + $urandom_range(3));
      p.second_end_x = p.second_start_x + (p.first_end_x - p.first_start_x);
      p.second_end_y = p.second_start_y + (p.first_end_y - p.first_start_y);
    end
    return p;
  endfunction

  initial begin
    segi_pkg::seg_out_t want;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      want = directed_rows[i].has_fixed ? directed_rows[i].fixed_result
                                        : intersect_segments(directed_rows[i].pair);
      maybe_idle(1'b0);
      send_pair(directed_rows[i].pair, want);
    end

    for (int n = 0; n < NumRandom; n++) begin
      segi_pkg::seg_in_t p;
      if (n == NumRandom / 2) begin
        // Hold off until the pipeline has drained completely.
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      maybe_idle(n >= 200 && n < 400);
      p = random_pair();
      send_pair(p, intersect_segments(p));
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/segi_pkg.sv
rtl/segi_div.sv
rtl/segment_intersection_core.sv
rtl/segi_chk.sv
tb/tb_top.sv
